/* hdl/e2q_pkg.sv */
// Shared constants and payload types for the Euler-angle to quaternion unit.
// No dependencies; imported by e2q_cordic and euler_to_quaternion_unit.
package e2q_pkg;

  // Field widths and CORDIC length
  localparam int ANGLE_BITS = 16;   // Q3.(ANGLE_BITS-3) input angles
  localparam int OUT_BITS   = 16;   // Q1.(OUT_BITS-2) quaternion parts
  localparam int TRIG_STEPS = 16;   // CORDIC iterations

  // Internal fixed-point formats
  localparam int WorkFrac = 30;                         // Q30 working fraction
  localparam int WorkW    = 34;                         // CORDIC / sum width
  localparam int TrigW    = 32;                         // sin, cos, products
  localparam int AngleUp  = WorkFrac - (ANGLE_BITS - 3) - 1;  // to Q30, halved
  localparam int OutShift = WorkFrac - (OUT_BITS - 2);

  // Pipeline stage map
  localparam int CordicStages = TRIG_STEPS + 2;  // fold, iterations, sign fix
  localparam int PairStage    = CordicStages;
  localparam int TripleStage  = CordicStages + 1;
  localparam int OutStage     = CordicStages + 2;
  localparam int NStages      = CordicStages + 3;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] quat_w;
    logic signed [OUT_BITS-1:0] quat_x;
    logic signed [OUT_BITS-1:0] quat_y;
    logic signed [OUT_BITS-1:0] quat_z;
  } e2q_out_t;

endpackage

/* hdl/euler_to_quaternion_unit.sv */
// Top level of the Euler-angle (ZYX) to unit-quaternion converter.
// Depends on e2q_pkg and e2q_cordic.
//
// Converts roll, pitch and yaw (radians, signed Q3.13) into the unit
// quaternion w, x, y, z (signed Q1.14, saturated to +-1.0) using the ZYX
// convention. One transfer can be taken every clock cycle while the output is
// not stalled. The pipeline starts with the CORDIC: one register stage for
// the angle fold, one per iteration, one for the sign fix, followed by a
// pair-product stage, a triple-product stage and the round/saturate output
// register. Every stage
// has its own valid bit and a stage loads whenever it is empty or its
// successor moves, so a stalled output only freezes the filled stages and
// bubbles keep closing up behind it. The block holds no state across items;
// reset only clears the valid bits.
module euler_to_quaternion_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  e2q_pkg::e2q_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output e2q_pkg::e2q_out_t out_data_o
);
  import e2q_pkg::*;

  localparam logic signed [63:0]       RoundHalf = 64'sd1 <<< (WorkFrac - 1);
  localparam logic signed [WorkW-1:0]  RoundOut  =
      (OutShift > 0) ? WorkW'(64'sd1 <<< (OutShift - 1)) : '0;
  localparam logic signed [WorkW-1:0]  LimW      = WorkW'(64'sd1 <<< (OUT_BITS - 2));
  localparam logic signed [WorkW-1:0]  NegLimW   = -LimW;
  localparam logic signed [OUT_BITS-1:0] LimO    = OUT_BITS'(64'sd1 <<< (OUT_BITS - 2));

  // Q30 x Q30 -> Q30, round half up
  function automatic logic signed [TrigW-1:0] mulw(input logic signed [TrigW-1:0] a,
                                                   input logic signed [TrigW-1:0] b);
    logic signed [2*TrigW-1:0] p;
    p = a * b;
    p = p + RoundHalf;
    return TrigW'(p >>> WorkFrac);
  endfunction

  // Q30 -> output format, round half up, clamp to +-1.0
  function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [WorkW-1:0] v);
    logic signed [WorkW-1:0] r;
    r = (v + RoundOut) >>> OutShift;
    if (r > LimW) r = LimW;
    if (r < NegLimW) r = NegLimW;
    return OUT_BITS'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Valid bits and per-stage advance (ready chain)
  // ---------------------------------------------------------------------------
  logic [NStages-1:0] v_q;
  logic [NStages-1:0] adv;

  always_comb begin
    adv[NStages-1] = !v_q[NStages-1] || out_ready_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStages; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NStages-1];

  // ---------------------------------------------------------------------------
  // Half-angle sine/cosine, one CORDIC lane per angle
  // ---------------------------------------------------------------------------
  logic signed [TrigW-1:0] sr, cr, sp, cp, sy, cy;

  e2q_cordic u_roll (
    .clk_i  (clk_i),
    .adv_i  (adv[CordicStages-1:0]),
    .angle_i(in_data_i.roll_angle),
    .sin_o  (sr),
    .cos_o  (cr)
  );

  e2q_cordic u_pitch (
    .clk_i  (clk_i),
    .adv_i  (adv[CordicStages-1:0]),
    .angle_i(in_data_i.pitch_angle),
    .sin_o  (sp),
    .cos_o  (cp)
  );

  e2q_cordic u_yaw (
    .clk_i  (clk_i),
    .adv_i  (adv[CordicStages-1:0]),
    .angle_i(in_data_i.yaw_angle),
    .sin_o  (sy),
    .cos_o  (cy)
  );

  // ---------------------------------------------------------------------------
  // Yaw/pitch pair products; roll terms ride along
  // ---------------------------------------------------------------------------
  logic signed [TrigW-1:0] cycp_q, sysp_q, sycp_q, cysp_q, cr_q, sr_q;

  always_ff @(posedge clk_i) begin
    if (adv[PairStage]) begin
      cycp_q <= mulw(cy, cp);
      sysp_q <= mulw(sy, sp);
      sycp_q <= mulw(sy, cp);
      cysp_q <= mulw(cy, sp);
      cr_q   <= cr;
      sr_q   <= sr;
    end
  end

  // ---------------------------------------------------------------------------
  // Triple products
  // ---------------------------------------------------------------------------
  logic signed [TrigW-1:0] w_a_q, w_b_q, x_a_q, x_b_q, y_a_q, y_b_q, z_a_q, z_b_q;

  always_ff @(posedge clk_i) begin
    if (adv[TripleStage]) begin
      w_a_q <= mulw(cycp_q, cr_q);
      w_b_q <= mulw(sysp_q, sr_q);
      x_a_q <= mulw(cycp_q, sr_q);
      x_b_q <= mulw(sysp_q, cr_q);
      y_a_q <= mulw(sycp_q, sr_q);
      y_b_q <= mulw(cysp_q, cr_q);
      z_a_q <= mulw(sycp_q, cr_q);
      z_b_q <= mulw(cysp_q, sr_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sum, round, saturate -> output register
  // ---------------------------------------------------------------------------
  e2q_out_t out_d, out_q;

  always_comb begin
    out_d.quat_w = to_out(WorkW'(w_a_q) + WorkW'(w_b_q));
    out_d.quat_x = to_out(WorkW'(x_a_q) - WorkW'(x_b_q));
    out_d.quat_y = to_out(WorkW'(y_a_q) + WorkW'(y_b_q));
    out_d.quat_z = to_out(WorkW'(z_a_q) - WorkW'(z_b_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv[OutStage]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // items in flight change only by transfers on the two ports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(v_q) == $past($countones(v_q)) + $past(int'(in_xfer))
                                 - $past(int'(out_xfer))))
    else $error("pipeline occupancy does not match transfers");

  // a full pipe behind a stalled output takes nothing new
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline full and stalled");

  // results stay within +-1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.quat_w <= LimO) && (out_data_o.quat_w >= -LimO) &&
                    (out_data_o.quat_x <= LimO) && (out_data_o.quat_x >= -LimO) &&
                    (out_data_o.quat_y <= LimO) && (out_data_o.quat_y >= -LimO) &&
                    (out_data_o.quat_z <= LimO) && (out_data_o.quat_z >= -LimO))
    else $error("quaternion component outside saturation range");

endmodule

/* hdl/e2q_cordic.sv */
// Pipelined rotation-mode CORDIC: sine and cosine of half an input angle, Q30.
// Depends on e2q_pkg; stage enables come from the top-level ready chain.
module e2q_cordic (
  input  logic                                 clk_i,
  input  logic [e2q_pkg::CordicStages-1:0]     adv_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] angle_i,
  output logic signed [e2q_pkg::TrigW-1:0]     sin_o,
  output logic signed [e2q_pkg::TrigW-1:0]     cos_o
);
  import e2q_pkg::*;

  localparam logic signed [WorkW-1:0] PiW        = WorkW'(64'sd3373259426);
  localparam logic signed [WorkW-1:0] HalfPiW    = WorkW'(64'sd1686629713);
  localparam logic signed [WorkW-1:0] NegHalfPiW = WorkW'(-64'sd1686629713);
  localparam logic signed [WorkW-1:0] GainW      = WorkW'(64'sd652032874);

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [WorkW-1:0] atan_step(input int i);
    logic signed [63:0] v;
    case (i)
      0:       v = 64'sd843314856;
      1:       v = 64'sd497837829;
      2:       v = 64'sd263043836;
      3:       v = 64'sd133525158;
      4:       v = 64'sd67021686;
      5:       v = 64'sd33543515;
      6:       v = 64'sd16775850;
      7:       v = 64'sd8388437;
      8:       v = 64'sd4194282;
      9:       v = 64'sd2097149;
      10:      v = 64'sd1048575;
      default: v = (i < 30) ? ((64'sd1 <<< (30 - i)) - 64'sd1) : 64'sd0;
    endcase
    return WorkW'(v);
  endfunction

  logic signed [WorkW-1:0] x_q [TRIG_STEPS+1];
  logic signed [WorkW-1:0] y_q [TRIG_STEPS+1];
  logic signed [WorkW-1:0] z_q [TRIG_STEPS];
  logic                    flip_q [TRIG_STEPS+1];
  logic signed [TrigW-1:0] sin_q, cos_q;

  logic signed [WorkW-1:0] z_scaled, z_fold;
  logic                    flip_d;

  // Half angle in Q30; fold beyond +-pi/2 by pi, negate results later
  always_comb begin
    z_scaled = WorkW'(angle_i) <<< AngleUp;
    z_fold   = z_scaled;
    flip_d   = 1'b0;
    if (z_scaled > HalfPiW) begin
      z_fold = z_scaled - PiW;
      flip_d = 1'b1;
    end else if (z_scaled < NegHalfPiW) begin
      z_fold = z_scaled + PiW;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      x_q[0]    <= GainW;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_iter
    localparam logic signed [WorkW-1:0] AtanI = atan_step(i);
    logic signed [WorkW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (adv_i[i+1]) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][WorkW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
        end
      end
    end

    // residual angle is not needed after the last iteration
    if (i < TRIG_STEPS - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (adv_i[i+1]) begin
          z_q[i+1] <= z_q[i][WorkW-1] ? (z_q[i] + AtanI) : (z_q[i] - AtanI);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[CordicStages-1]) begin
      sin_q <= flip_q[TRIG_STEPS] ? TrigW'(-y_q[TRIG_STEPS]) : TrigW'(y_q[TRIG_STEPS]);
      cos_q <= flip_q[TRIG_STEPS] ? TrigW'(-x_q[TRIG_STEPS]) : TrigW'(x_q[TRIG_STEPS]);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
